[rtl/core/accel_magnitude_jerk_meter_macros.svh]
// Assertion macros shared by the accelerometer magnitude and jerk meter RTL.
`ifndef ACCEL_MAGNITUDE_JERK_METER_MACROS_SVH
`define ACCEL_MAGNITUDE_JERK_METER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge out of reset.
`define AJM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ajm check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define AJM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ajm check failed");

`else

`define AJM_ASSERT_SAME(label, ante, cons)

`define AJM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/ajm_pkg.sv]
// Shared types and constants of the accelerometer magnitude and jerk meter.
package ajm_pkg;

  localparam int AXIS_W     = 16;   // signed axis sample width
  localparam int SQ_W       = 32;   // square and sum-of-squares width
  localparam int MAG_W      = 16;   // magnitude and jerk width
  localparam int DIVR_W     = 10;   // interval divisor register width
  localparam int SPR_W      = 4;    // samples-per-result register width
  localparam int CFG_IDX_W  = 2;    // configuration index width
  localparam int CFG_DATA_W = 10;   // configuration data width
  localparam int NUM_AXES   = 3;

  // Radix-4 square: two multiplier bits per cycle
  localparam int SQ_STEPS   = AXIS_W / 2;
  localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
  localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_STEPS - 1);

  // Square root: one result bit per cycle
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int ROOT_REM_W = MAG_W + 2;
  localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = ROOT_CNT_W'(ROOT_STEPS - 1);

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS  = MAG_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // Register reset values
  localparam logic [DIVR_W-1:0] INTERVAL_DIVISOR_RST   = DIVR_W'(50);
  localparam logic [SPR_W-1:0]  SAMPLES_PER_RESULT_RST = SPR_W'(5);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_DIVISOR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_RESULT = CFG_IDX_W'(1);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_DIVIDE,
    S_FINISH
  } ajm_state_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ajm_unit_stat_t;

endpackage

[rtl/core/ajm_sqrt.sv]
// Digit-serial floor square root, one root bit per cycle.
module ajm_sqrt
  import ajm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_W-1:0]      radicand,
  output ajm_unit_stat_t       stat,
  output logic [MAG_W-1:0]     root
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SQ_W-1:0]       rad_r, rad_nxt;
  logic [ROOT_REM_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0]      root_r, root_nxt;

  logic [ROOT_REM_W+1:0] rem_shift;
  logic [ROOT_REM_W+1:0] trial;
  logic [ROOT_REM_W+1:0] rem_diff;
  logic                  fits;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_shift = {rem_r, rad_r[SQ_W-1 -: 2]};
    trial     = (ROOT_REM_W + 2)'({root_r, 2'b01});
    fits      = (rem_shift >= trial);
    rem_diff  = rem_shift - trial;
  end

  // Advance one digit per cycle while busy
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[SQ_W-3:0], 2'b00};
      rem_nxt  = fits ? rem_diff[ROOT_REM_W-1:0] : rem_shift[ROOT_REM_W-1:0];
      root_nxt = {root_r[MAG_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == ROOT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

[rtl/core/ajm_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module ajm_div
  import ajm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MAG_W-1:0]   dividend,
  input  logic [DIVR_W-1:0]  divisor,
  output ajm_unit_stat_t     stat,
  output logic [MAG_W-1:0]   quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0]     quo_r, quo_nxt;
  logic [DIVR_W-1:0]    rem_r, rem_nxt;
  logic [DIVR_W-1:0]    dvs_r, dvs_nxt;

  logic [DIVR_W:0]      rem_shift;
  logic [DIVR_W:0]      rem_diff;
  logic                 fits;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_shift = {rem_r, quo_r[MAG_W-1]};
    fits      = (rem_shift >= {1'b0, dvs_r});
    rem_diff  = rem_shift - {1'b0, dvs_r};
  end

  // Advance one quotient bit per cycle while busy
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];
      quo_nxt = {quo_r[MAG_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[rtl/core/accel_magnitude_jerk_meter.sv]
// Top level of the accelerometer magnitude and jerk meter.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word of three signed 16-bit
//   axis samples. The block handles one sample at a time: in_ready is high
//   only while the sequencer is idle.
//   From acceptance, a sample passes through radix-4 squaring (three lanes
//   in parallel), the addition of the squares, the bit-serial square root
//   and the bit-serial divider, then retires; the sequencer returns to idle
//   before it accepts the next sample, so samples never overlap.
//   Result channel (out_valid/out_ready) carries magnitude and jerk on every
//   samples_per_result-th sample; the others only update the running state.
//   The result sits in an output register. If the receiver stalls, the
//   finished result waits there; a further result that must be emitted
//   holds the sequencer until the register frees up.
//   Configuration (cfg_we/cfg_index/cfg_wdata) writes take effect at once;
//   write them only while idle. Reset clears the previous magnitude, the
//   sample counter and the output valid flag, and loads interval 50 and
//   five samples per result. There is no memory to clear.
`include "accel_magnitude_jerk_meter_macros.svh"

module accel_magnitude_jerk_meter
  import ajm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [AXIS_W-1:0]     in_accel_x,
  input  logic signed [AXIS_W-1:0]     in_accel_y,
  input  logic signed [AXIS_W-1:0]     in_accel_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [MAG_W-1:0]             out_magnitude,
  output logic [MAG_W-1:0]             out_jerk,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  ajm_state_t state_r, state_nxt;

  logic [DIVR_W-1:0]   interval_div_r, interval_div_nxt;
  logic [SPR_W-1:0]    samples_per_res_r, samples_per_res_nxt;
  logic [MAG_W-1:0]    prev_mag_r, prev_mag_nxt;
  logic [SPR_W-1:0]    sample_cnt_r, sample_cnt_nxt;
  logic [SQ_CNT_W-1:0] step_cnt_r, step_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MAG_W-1:0]    out_mag_r, out_mag_nxt;
  logic [MAG_W-1:0]    out_jerk_r, out_jerk_nxt;

  // Squaring lanes: multiplicand, its triple, multiplier digits, product
  logic [AXIS_W-1:0]   mcand_r [NUM_AXES];
  logic [AXIS_W+1:0]   mcand3_r [NUM_AXES];
  logic [AXIS_W-1:0]   mplier_r [NUM_AXES];
  logic [SQ_W-1:0]     prod_r [NUM_AXES];
  logic [AXIS_W-1:0]   mcand_nxt [NUM_AXES];
  logic [AXIS_W+1:0]   mcand3_nxt [NUM_AXES];
  logic [AXIS_W-1:0]   mplier_nxt [NUM_AXES];
  logic [SQ_W-1:0]     prod_nxt [NUM_AXES];

  logic [AXIS_W-1:0]   raw_axis [NUM_AXES];
  logic [AXIS_W-1:0]   abs_axis [NUM_AXES];
  logic [AXIS_W+1:0]   part_prod [NUM_AXES];

  // Sequencer outputs
  logic lanes_load;
  logic lanes_step;
  logic root_start;
  logic div_start;
  logic retire;
  logic out_load;

  logic [SQ_W-1:0]   sum_sq;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_diff;
  logic [MAG_W-1:0]  quotient;
  logic [DIVR_W-1:0] divisor_eff;
  logic [SPR_W-1:0]  need;
  logic [SPR_W-1:0]  cnt_inc;
  logic              emit;

  ajm_unit_stat_t root_stat;
  ajm_unit_stat_t div_stat;

  // Configuration registers
  always_comb begin
    interval_div_nxt    = interval_div_r;
    samples_per_res_nxt = samples_per_res_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL_DIVISOR:   interval_div_nxt    = cfg_wdata[DIVR_W-1:0];
        REG_SAMPLES_PER_RESULT: samples_per_res_nxt = cfg_wdata[SPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Take absolute values of the axes; 0x8000 stays 32768 unsigned
  always_comb begin
    raw_axis[0] = in_accel_x;
    raw_axis[1] = in_accel_y;
    raw_axis[2] = in_accel_z;
    for (int i = 0; i < NUM_AXES; i++) begin
      abs_axis[i] = raw_axis[i][AXIS_W-1] ? (~raw_axis[i] + 1'b1) : raw_axis[i];
    end
  end

  // Square each lane two multiplier bits per cycle, most significant first
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      unique case (mplier_r[i][AXIS_W-1 -: 2])
        2'd0:    part_prod[i] = '0;
        2'd1:    part_prod[i] = {2'b00, mcand_r[i]};
        2'd2:    part_prod[i] = {1'b0, mcand_r[i], 1'b0};
        default: part_prod[i] = mcand3_r[i];
      endcase
      mcand_nxt[i]  = mcand_r[i];
      mcand3_nxt[i] = mcand3_r[i];
      mplier_nxt[i] = mplier_r[i];
      prod_nxt[i]   = prod_r[i];
      if (lanes_load) begin
        mcand_nxt[i]  = abs_axis[i];
        mcand3_nxt[i] = {2'b00, abs_axis[i]} + {1'b0, abs_axis[i], 1'b0};
        mplier_nxt[i] = abs_axis[i];
        prod_nxt[i]   = '0;
      end else if (lanes_step) begin
        mplier_nxt[i] = {mplier_r[i][AXIS_W-3:0], 2'b00};
        prod_nxt[i]   = {prod_r[i][SQ_W-3:0], 2'b00} + SQ_W'(part_prod[i]);
      end
    end
  end

  // Step counter for the squaring phase
  always_comb begin
    step_cnt_nxt = step_cnt_r;
    if (lanes_load) begin
      step_cnt_nxt = '0;
    end else if (lanes_step) begin
      step_cnt_nxt = step_cnt_r + 1'b1;
    end
  end

  // Add the squares; the total stays below 2^32
  assign sum_sq = prod_r[0] + prod_r[1] + prod_r[2];

  ajm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sum_sq),
    .stat     (root_stat),
    .root     (mag)
  );

  // Form the magnitude change and the effective divisor
  always_comb begin
    mag_diff    = (mag >= prev_mag_r) ? (mag - prev_mag_r) : (prev_mag_r - mag);
    divisor_eff = (interval_div_r == '0) ? DIVR_W'(1) : interval_div_r;
  end

  ajm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_diff),
    .divisor  (divisor_eff),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Decide whether this sample emits a result
  always_comb begin
    need    = (samples_per_res_r == '0) ? SPR_W'(1) : samples_per_res_r;
    cnt_inc = sample_cnt_r + 1'b1;
    emit    = (cnt_inc >= need) || (cnt_inc == '0);
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SQUARE;
      S_SQUARE: if (step_cnt_r == SQ_LAST) state_nxt = S_SUM;
      S_SUM:    state_nxt = S_ROOT;
      S_ROOT:   if (root_stat.done) state_nxt = S_DIVIDE;
      S_DIVIDE: if (div_stat.done) state_nxt = S_FINISH;
      S_FINISH: if (!emit || !out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    lanes_load = 1'b0;
    lanes_step = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    retire     = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        lanes_load = in_valid;
      end
      S_SQUARE: lanes_step = 1'b1;
      S_SUM:    root_start = 1'b1;
      S_ROOT:   div_start  = root_stat.done;
      S_DIVIDE: ;
      S_FINISH: begin
        retire   = !emit || !out_valid_r || out_ready;
        out_load = emit && (!out_valid_r || out_ready);
      end
      default: ;
    endcase
  end

  // Update running state and the output register
  always_comb begin
    prev_mag_nxt   = prev_mag_r;
    sample_cnt_nxt = sample_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_mag_nxt    = out_mag_r;
    out_jerk_nxt   = out_jerk_r;
    if (retire) begin
      prev_mag_nxt   = mag;
      sample_cnt_nxt = emit ? '0 : cnt_inc;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_mag_nxt   = mag;
      out_jerk_nxt  = quotient;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      interval_div_r    <= INTERVAL_DIVISOR_RST;
      samples_per_res_r <= SAMPLES_PER_RESULT_RST;
      prev_mag_r        <= '0;
      sample_cnt_r      <= '0;
      step_cnt_r        <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      interval_div_r    <= interval_div_nxt;
      samples_per_res_r <= samples_per_res_nxt;
      prev_mag_r        <= prev_mag_nxt;
      sample_cnt_r      <= sample_cnt_nxt;
      step_cnt_r        <= step_cnt_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mag_r  <= out_mag_nxt;
    out_jerk_r <= out_jerk_nxt;
    for (int i = 0; i < NUM_AXES; i++) begin
      mcand_r[i]  <= mcand_nxt[i];
      mcand3_r[i] <= mcand3_nxt[i];
      mplier_r[i] <= mplier_nxt[i];
      prod_r[i]   <= prod_nxt[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_jerk      = out_jerk_r;

  // Checks on the sequencer and the arithmetic units
  `AJM_ASSERT_NEXT(a_accept_starts_square, in_valid && in_ready, state_r == S_SQUARE)
  `AJM_ASSERT_SAME(a_root_done_in_root, root_stat.done, state_r == S_ROOT)
  `AJM_ASSERT_SAME(a_div_done_in_divide, div_stat.done, state_r == S_DIVIDE)
  `AJM_ASSERT_SAME(a_no_overwrite, out_load, !out_valid_r || out_ready)
  `AJM_ASSERT_SAME(a_units_exclusive, root_stat.busy, !div_stat.busy)

endmodule

[tb/accel_magnitude_jerk_meter_checker.sv]
// Checker for the accelerometer magnitude and jerk meter: predicts and compares readings.
module accel_magnitude_jerk_meter_checker
  import ajm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [MAG_W-1:0]         out_magnitude,
  input  logic [MAG_W-1:0]         out_jerk,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  output int                       fail_count,
  output int                       pending,
  output int                       samples_taken,
  output int                       readings_checked
);

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] jerk;
  } reading_t;

  // Shadow of the block's registers and running state
  logic [DIVR_W-1:0] divisor_q;
  logic [SPR_W-1:0]  per_result_q;
  logic [MAG_W-1:0]  last_mag;
  logic [SPR_W-1:0]  sample_cnt;

  reading_t expected_readings[$];
  reading_t due;
  int       errors;
  int       n_in;
  int       n_out;

  function automatic logic [33:0] axis_square(input logic signed [AXIS_W-1:0] a);
    logic [33:0] m;
    m = (a < 0) ? 34'(-int'(a)) : 34'(int'(a));
    return m * m;
  endfunction

  // Advance the shadow state by one sample; queue a reading when one is due
  task automatic predict_reading(input logic signed [AXIS_W-1:0] x,
                                 input logic signed [AXIS_W-1:0] y,
                                 input logic signed [AXIS_W-1:0] z);
    logic [33:0]       energy;
    logic [MAG_W:0]    root;
    logic [MAG_W:0]    trial;
    longint unsigned   t;
    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  delta;
    logic [DIVR_W-1:0] div;
    logic [SPR_W-1:0]  need;
    reading_t          r;
    energy = axis_square(x) + axis_square(y) + axis_square(z);
    // Build the floor root one bit at a time, most significant first
    root = '0;
    for (int b = MAG_W; b >= 0; b--) begin
      trial = root | ((MAG_W+1)'(1) << b);
      t = trial;
      if (t * t <= energy) root = trial;
    end
    mag = root[MAG_W-1:0];
    delta = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
    div = (divisor_q == '0) ? DIVR_W'(1) : divisor_q;
    need = (per_result_q == '0) ? SPR_W'(1) : per_result_q;
    r.magnitude = mag;
    r.jerk = delta / div;
    last_mag = mag;
    sample_cnt = sample_cnt + SPR_W'(1);
    if (sample_cnt >= need || sample_cnt == '0) begin
      sample_cnt = '0;
      expected_readings.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      divisor_q = INTERVAL_DIVISOR_RST;
      per_result_q = SAMPLES_PER_RESULT_RST;
      last_mag = '0;
      sample_cnt = '0;
      expected_readings.delete();
      errors = 0;
      n_in = 0;
      n_out = 0;
    end else begin
      // Track register writes; unmapped indexes change nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_INTERVAL_DIVISOR:   divisor_q = cfg_wdata[DIVR_W-1:0];
          REG_SAMPLES_PER_RESULT: per_result_q = cfg_wdata[SPR_W-1:0];
          default: ;
        endcase
      end
      // Compare each result word against the oldest expectation
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: reading with none expected, actual magnitude %0d jerk %0d",
                   $time, out_magnitude, out_jerk);
        end else begin
          due = expected_readings.pop_front();
          if (out_magnitude !== due.magnitude) begin
            errors++;
            $display("%0t: magnitude mismatch, expected %0d, actual %0d",
                     $time, due.magnitude, out_magnitude);
          end
          if (out_jerk !== due.jerk) begin
            errors++;
            $display("%0t: jerk mismatch, expected %0d, actual %0d",
                     $time, due.jerk, out_jerk);
          end
        end
      end
      // Predict from each accepted sample word
      if (in_valid && in_ready) begin
        n_in++;
        predict_reading(in_accel_x, in_accel_y, in_accel_z);
      end
    end
    pending <= expected_readings.size();
    fail_count <= errors;
    samples_taken <= n_in;
    readings_checked <= n_out;
  end

endmodule

[tb/tb_accel_magnitude_jerk_meter.sv]
// Top of the magnitude and jerk meter testbench: clock, reset, stimulus and verdict.
module tb_accel_magnitude_jerk_meter
  import ajm_pkg::*;
();

  localparam int STALL_MAX      = 12;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SAMPLE_TARGET  = 750;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [AXIS_W-1:0] in_accel_x;
  logic signed [AXIS_W-1:0] in_accel_y;
  logic signed [AXIS_W-1:0] in_accel_z;
  logic                     out_valid;
  logic                     out_ready;
  logic [MAG_W-1:0]         out_magnitude;
  logic [MAG_W-1:0]         out_jerk;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;

  int fail_count;
  int pending;
  int samples_taken;
  int readings_checked;
  int idle_cycles = 0;
  int samples_sent;
  int settings_used;
  bit no_gaps;

  accel_magnitude_jerk_meter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_accel_x   (in_accel_x),
    .in_accel_y   (in_accel_y),
    .in_accel_z   (in_accel_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_magnitude(out_magnitude),
    .out_jerk     (out_jerk),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  accel_magnitude_jerk_meter_checker meter_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_accel_x      (in_accel_x),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_magnitude   (out_magnitude),
    .out_jerk        (out_jerk),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .samples_taken   (samples_taken),
    .readings_checked(readings_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort when no word moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no handshake for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drain result words with a random stall before each one
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one sample word after a random gap; return once it is taken
  task automatic send_sample(input logic signed [AXIS_W-1:0] x,
                             input logic signed [AXIS_W-1:0] y,
                             input logic signed [AXIS_W-1:0] z);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    do @(posedge clk); while (!(in_valid && in_ready));
    samples_sent++;
  endtask

  // Drop valid, wait out every pending reading, then let the sequencer finish
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pick one axis value: full range, corner, small, or close to the last one
  function automatic logic signed [AXIS_W-1:0] draw_axis(
      input int mode, input logic signed [AXIS_W-1:0] base);
    int v;
    case (mode)
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'hFFFF;
          3: v = 16'h0001;
          default: v = 0;
        endcase
      end
      2: v = $urandom_range(0, 512) - 256;
      default: v = int'(base) + $urandom_range(0, 32) - 16;
    endcase
    return AXIS_W'(v);
  endfunction

  initial begin
    logic signed [AXIS_W-1:0] px;
    logic signed [AXIS_W-1:0] py;
    logic signed [AXIS_W-1:0] pz;
    int phase_len;
    int mode;
    logic [CFG_DATA_W-1:0] value;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    cfg_we = 1'b0;
    cfg_index = REG_INTERVAL_DIVISOR;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    samples_sent = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default interval, count masked down to zero so every sample emits;
    // the first reading is measured against a previous magnitude of zero
    write_reg(REG_SAMPLES_PER_RESULT, 10'h3F0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh8000, 16'sh0000, 16'sh0000);
    send_sample(16'sh0000, 16'sh7FFF, 16'sh0000);
    send_sample(16'sh0000, 16'sh0000, 16'shFFFF);
    send_sample(16'sh0001, 16'shFFFF, 16'sh0001);
    quiesce();

    // Zero interval acts as one
    write_reg(REG_INTERVAL_DIVISOR, 10'd0);
    write_reg(REG_SAMPLES_PER_RESULT, 10'd1);
    settings_used++;
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sd3, 16'sd4, 16'sd0);
    send_sample(-16'sd12, 16'sd0, 16'sd5);
    quiesce();

    // Largest interval and count; leave four samples in the counter
    write_reg(REG_INTERVAL_DIVISOR, 10'd1023);
    write_reg(REG_SAMPLES_PER_RESULT, 10'd15);
    settings_used++;
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000, 16'sh0001);
    send_sample(16'sh7FFF, 16'sh0000, 16'sh8000);
    send_sample(16'sh0100, 16'shFF00, 16'sh0010);
    quiesce();

    // Lower the count below the counter: next sample emits at once.
    // Spare indexes must leave both registers alone.
    write_reg(REG_SAMPLES_PER_RESULT, 10'h3F3);
    write_reg(REG_SPARE_LO, 10'h3FF);
    write_reg(REG_SPARE_HI, 10'h000);
    settings_used++;
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'sh8000, 16'sh0000);
    quiesce();

    // Random phases, each under a freshly drawn setting
    px = '0;
    py = '0;
    pz = '0;
    while (samples_sent < SAMPLE_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0: value = 10'd0;
          1: value = 10'd1;
          2: value = 10'd1023;
          3: value = CFG_DATA_W'($urandom_range(1, 8));
          default: value = CFG_DATA_W'($urandom_range(0, 1023));
        endcase
        write_reg(REG_INTERVAL_DIVISOR, value);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0: value = 10'd0;
          1: value = 10'd1;
          2: value = 10'd15;
          3: value = CFG_DATA_W'($urandom_range(1, 6));
          default: value = CFG_DATA_W'($urandom_range(0, 1023));
        endcase
        write_reg(REG_SAMPLES_PER_RESULT, value);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_DATA_W'($urandom));
      settings_used++;
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        mode = $urandom_range(0, 3);
        px = draw_axis(mode, px);
        py = draw_axis(mode, py);
        pz = draw_axis(mode, pz);
        send_sample(px, py, pz);
      end
      quiesce();
    end

    $display("Covered %0d accel samples under %0d register settings, %0d readings checked",
             samples_taken, settings_used, readings_checked);
    $display("Settings spanned zero, one and full-scale interval and count values");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
